// ===== src/two_level_direct_mapped_cache_unit_defines.svh =====
// Assertion macros for the two-level cache unit.
// Assertions are sampled on clk_i and are off while rst_ni is low.
`ifndef TWO_LEVEL_DIRECT_MAPPED_CACHE_UNIT_DEFINES_SVH
`define TWO_LEVEL_DIRECT_MAPPED_CACHE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TLC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
`define TLC_ASSERT_NEVER(lbl, cond) `TLC_ASSERT(lbl, !(cond))
`else
`define TLC_ASSERT(lbl, prop)
`define TLC_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== src/tlc_pkg.sv =====
package tlc_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned AddrW     = 8;
  localparam int unsigned MemWords  = 256;
  localparam int unsigned LineWords = 4;
  localparam int unsigned L1Lines   = 4;
  localparam int unsigned L2Lines   = 8;

  // Line size and line counts are powers of two: offset and index are address bits.
  localparam int unsigned OffW = $clog2(LineWords);
  localparam int unsigned BlkW = AddrW - OffW;
  localparam int unsigned CntW = $clog2(LineWords + 1);
  localparam int unsigned SrcW = 2;

  typedef enum logic {
    OP_READ = 1'b0,
    OP_LOAD = 1'b1
  } tlc_op_e;

  typedef enum logic [SrcW-1:0] {
    SRC_L1   = 2'd0,
    SRC_L2   = 2'd1,
    SRC_MEM  = 2'd2,
    SRC_LOAD = 2'd3
  } tlc_src_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_FILL,
    ST_RESP
  } tlc_state_e;

  // Line fill command from the sequencer to one cache level.
  typedef struct packed {
    logic             word_we;
    logic [OffW-1:0]  word_off;
    logic [DataW-1:0] word;
    logic             tag_we;
  } tlc_fill_t;

endpackage

// ===== src/tlc_level.sv =====
module tlc_level #(
  parameter int unsigned Lines = tlc_pkg::L1Lines
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tlc_pkg::BlkW-1:0]   blk_i,
  input  logic                       rd_en_i,
  input  logic [tlc_pkg::AddrW-1:0]  rd_addr_i,
  input  tlc_pkg::tlc_fill_t         fill_i,
  output logic                       hit_o,
  output logic [tlc_pkg::DataW-1:0]  rd_data_o
);

  localparam int unsigned IdxW  = $clog2(Lines);
  localparam int unsigned Words = Lines * tlc_pkg::LineWords;

  logic [Lines-1:0]              valid_q;
  logic [tlc_pkg::BlkW-1:0]      tag_q [Lines];
  logic [tlc_pkg::DataW-1:0]     words_q [Words];
  logic [tlc_pkg::DataW-1:0]     rd_data_q;
  logic [IdxW-1:0]               line;
  logic [IdxW-1:0]               rd_line;
  logic [tlc_pkg::OffW-1:0]      rd_off;

  assign line    = blk_i[IdxW-1:0];
  assign rd_line = rd_addr_i[tlc_pkg::OffW +: IdxW];
  assign rd_off  = rd_addr_i[tlc_pkg::OffW-1:0];

  assign hit_o     = valid_q[line] && (tag_q[line] == blk_i);
  assign rd_data_o = rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < Lines; i++) begin
        tag_q[i] <= '0;
      end
    end else if (fill_i.tag_we) begin
      valid_q[line] <= 1'b1;
      tag_q[line]   <= blk_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_i.word_we) begin
      words_q[{line, fill_i.word_off}] <= fill_i.word;
    end
    if (rd_en_i) begin
      rd_data_q <= words_q[{rd_line, rd_off}];
    end
  end

endmodule

// ===== src/two_level_direct_mapped_cache_unit.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid_i/in_stall_o   operation_i, address_i, write_data_i
// out      output     out_valid_o/out_stall_i read_data_o, source_o
//
// One item at a time; in_stall_o is high from acceptance until the result is registered.
// A memory load goes from IDLE to RESP; an L1 hit passes DECIDE and RESP; an L1 miss
// also passes FILL, where the single-ported backing memory gives one word per cycle.
// The result waits in an output register while out_stall_i is high.
// Reset clears valid bits and tags of both levels; backing memory is not cleared.
`include "two_level_direct_mapped_cache_unit_defines.svh"

module two_level_direct_mapped_cache_unit #(
  parameter int unsigned L1Lines = tlc_pkg::L1Lines,
  parameter int unsigned L2Lines = tlc_pkg::L2Lines
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       operation_i,
  input  logic [tlc_pkg::AddrW-1:0]  address_i,
  input  logic [tlc_pkg::DataW-1:0]  write_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tlc_pkg::DataW-1:0]  read_data_o,
  output logic [tlc_pkg::SrcW-1:0]   source_o
);

  tlc_pkg::tlc_state_e state_q, state_d;

  logic [tlc_pkg::AddrW-1:0]  addr_q, addr_d;
  logic [tlc_pkg::DataW-1:0]  data_q, data_d;
  tlc_pkg::tlc_src_e          src_q, src_d;
  logic [tlc_pkg::CntW-1:0]   fill_cnt_q, fill_cnt_d;
  logic                       wr_pend_q, wr_pend_d;
  logic [tlc_pkg::OffW-1:0]   wr_off_q, wr_off_d;
  logic                       l2_miss_q, l2_miss_d;
  logic                       out_valid_q, out_valid_d;
  logic [tlc_pkg::DataW-1:0]  out_data_q;
  logic [tlc_pkg::SrcW-1:0]   out_src_q;

  logic [tlc_pkg::DataW-1:0]  mem_q [tlc_pkg::MemWords];
  logic [tlc_pkg::DataW-1:0]  mem_rd_q;
  logic [tlc_pkg::AddrW-1:0]  mem_addr;
  logic                       mem_we;
  logic                       mem_re;

  logic                       accept;
  logic                       is_load;
  logic                       fill_more;
  logic                       fill_done;
  logic                       resp_fire;
  logic [tlc_pkg::BlkW-1:0]   blk;
  logic [tlc_pkg::OffW-1:0]   off;
  logic                       l1_hit, l2_hit;
  logic [tlc_pkg::DataW-1:0]  l1_rd, l2_rd;
  logic [tlc_pkg::DataW-1:0]  fill_word;
  tlc_pkg::tlc_fill_t         l1_fill, l2_fill;

  assign in_stall_o = (state_q != tlc_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_load    = (operation_i == tlc_pkg::OP_LOAD);
  assign blk        = addr_q[tlc_pkg::AddrW-1:tlc_pkg::OffW];
  assign off        = addr_q[tlc_pkg::OffW-1:0];
  assign fill_more  = (state_q == tlc_pkg::ST_FILL) &&
                      (fill_cnt_q < tlc_pkg::CntW'(tlc_pkg::LineWords));
  assign fill_done  = (state_q == tlc_pkg::ST_FILL) && !fill_more;
  assign resp_fire  = (state_q == tlc_pkg::ST_RESP) && (!out_valid_q || !out_stall_i);

  // Single memory port: load writes and lookup reads at acceptance, line reads in fill.
  assign mem_addr = (state_q == tlc_pkg::ST_FILL) ?
                    {blk, fill_cnt_q[tlc_pkg::OffW-1:0]} : address_i;
  assign mem_we   = accept && is_load;
  assign mem_re   = (accept && !is_load) || fill_more;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= write_data_i;
    end
    if (mem_re) begin
      mem_rd_q <= mem_q[mem_addr];
    end
  end

  // Line word from memory, except the requested word, which takes the returned value.
  assign fill_word = (wr_off_q == off) ? data_q : mem_rd_q;

  always_comb begin
    l1_fill.word_we  = wr_pend_q;
    l1_fill.word_off = wr_off_q;
    l1_fill.word     = fill_word;
    l1_fill.tag_we   = fill_done;
    l2_fill.word_we  = wr_pend_q && l2_miss_q;
    l2_fill.word_off = wr_off_q;
    l2_fill.word     = fill_word;
    l2_fill.tag_we   = fill_done && l2_miss_q;
  end

  tlc_level #(
    .Lines(L1Lines)
  ) u_l1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .blk_i     (blk),
    .rd_en_i   (accept),
    .rd_addr_i (address_i),
    .fill_i    (l1_fill),
    .hit_o     (l1_hit),
    .rd_data_o (l1_rd)
  );

  tlc_level #(
    .Lines(L2Lines)
  ) u_l2 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .blk_i     (blk),
    .rd_en_i   (accept),
    .rd_addr_i (address_i),
    .fill_i    (l2_fill),
    .hit_o     (l2_hit),
    .rd_data_o (l2_rd)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tlc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = is_load ? tlc_pkg::ST_RESP : tlc_pkg::ST_DECIDE;
        end
      end
      tlc_pkg::ST_DECIDE: begin
        state_d = l1_hit ? tlc_pkg::ST_RESP : tlc_pkg::ST_FILL;
      end
      tlc_pkg::ST_FILL: begin
        if (fill_done) begin
          state_d = tlc_pkg::ST_RESP;
        end
      end
      tlc_pkg::ST_RESP: begin
        if (resp_fire) begin
          state_d = tlc_pkg::ST_IDLE;
        end
      end
      default: state_d = tlc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    addr_d      = addr_q;
    data_d      = data_q;
    src_d       = src_q;
    fill_cnt_d  = fill_cnt_q;
    wr_pend_d   = 1'b0;
    wr_off_d    = wr_off_q;
    l2_miss_d   = l2_miss_q;
    out_valid_d = (out_valid_q && out_stall_i) || resp_fire;
    unique case (state_q)
      tlc_pkg::ST_IDLE: begin
        if (accept) begin
          addr_d = address_i;
          data_d = '0;
          src_d  = tlc_pkg::SRC_LOAD;
        end
      end
      tlc_pkg::ST_DECIDE: begin
        fill_cnt_d = '0;
        if (l1_hit) begin
          data_d = l1_rd;
          src_d  = tlc_pkg::SRC_L1;
        end else if (l2_hit) begin
          data_d    = l2_rd;
          src_d     = tlc_pkg::SRC_L2;
          l2_miss_d = 1'b0;
        end else begin
          data_d    = mem_rd_q;
          src_d     = tlc_pkg::SRC_MEM;
          l2_miss_d = 1'b1;
        end
      end
      tlc_pkg::ST_FILL: begin
        // Read issued this cycle is written into the levels in the next cycle.
        if (fill_more) begin
          fill_cnt_d = fill_cnt_q + 1'b1;
          wr_pend_d  = 1'b1;
          wr_off_d   = fill_cnt_q[tlc_pkg::OffW-1:0];
        end
      end
      tlc_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlc_pkg::ST_IDLE;
      fill_cnt_q  <= '0;
      wr_pend_q   <= 1'b0;
      l2_miss_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_cnt_q  <= fill_cnt_d;
      wr_pend_q   <= wr_pend_d;
      l2_miss_q   <= l2_miss_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    data_q   <= data_d;
    src_q    <= src_d;
    wr_off_q <= wr_off_d;
    if (resp_fire) begin
      out_data_q <= data_q;
      out_src_q  <= src_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign source_o    = out_src_q;

  `TLC_ASSERT(a_busy_after_accept, accept |=> state_q != tlc_pkg::ST_IDLE)
  `TLC_ASSERT(a_resp_to_out, resp_fire |=> out_valid_o && state_q == tlc_pkg::ST_IDLE)
  `TLC_ASSERT_NEVER(a_cnt_bound, fill_cnt_q > tlc_pkg::CntW'(tlc_pkg::LineWords))
  `TLC_ASSERT(a_l1_hit_after_fill, fill_done |=> l1_hit)
  `TLC_ASSERT(a_l2_hit_after_fill, (fill_done && l2_miss_q) |=> l2_hit)

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 650;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned TailCycles  = 16;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned NumDirected = 21;

  typedef struct packed {
    logic [tlc_pkg::DataW-1:0] data;
    tlc_pkg::tlc_src_e         src;
  } resp_t;

  typedef struct packed {
    bit                        known;
    tlc_pkg::tlc_op_e          op;
    logic [tlc_pkg::AddrW-1:0] addr;
    logic [tlc_pkg::DataW-1:0] wdata;
    logic [tlc_pkg::DataW-1:0] data;
    tlc_pkg::tlc_src_e         src;
  } dir_row_t;

  // Directed rows: extremes of data, every source, stale copy after a load,
  // L1 and L2 conflict evictions, read with write_data all ones.
  localparam dir_row_t DirectedRows [NumDirected] = '{
    '{1'b1, tlc_pkg::OP_LOAD, 8'd0,   32'h0000_0000, 32'h0000_0000, tlc_pkg::SRC_LOAD},
    '{1'b1, tlc_pkg::OP_LOAD, 8'd1,   32'hFFFF_FFFF, 32'h0000_0000, tlc_pkg::SRC_LOAD},
    '{1'b1, tlc_pkg::OP_LOAD, 8'd2,   32'hA5A5_A5A5, 32'h0000_0000, tlc_pkg::SRC_LOAD},
    '{1'b1, tlc_pkg::OP_LOAD, 8'd3,   32'h5A5A_5A5A, 32'h0000_0000, tlc_pkg::SRC_LOAD},
    '{1'b1, tlc_pkg::OP_READ, 8'd1,   32'h0000_0000, 32'hFFFF_FFFF, tlc_pkg::SRC_MEM},
    '{1'b1, tlc_pkg::OP_READ, 8'd2,   32'hFFFF_FFFF, 32'hA5A5_A5A5, tlc_pkg::SRC_L1},
    '{1'b1, tlc_pkg::OP_LOAD, 8'd252, 32'h0000_0001, 32'h0000_0000, tlc_pkg::SRC_LOAD},
    '{1'b1, tlc_pkg::OP_LOAD, 8'd253, 32'h7FFF_FFFE, 32'h0000_0000, tlc_pkg::SRC_LOAD},
    '{1'b1, tlc_pkg::OP_LOAD, 8'd254, 32'h8000_0001, 32'h0000_0000, tlc_pkg::SRC_LOAD},
    '{1'b1, tlc_pkg::OP_LOAD, 8'd255, 32'hFFFF_FFFF, 32'h0000_0000, tlc_pkg::SRC_LOAD},
    '{1'b1, tlc_pkg::OP_READ, 8'd255, 32'h0000_0000, 32'hFFFF_FFFF, tlc_pkg::SRC_MEM},
    '{1'b1, tlc_pkg::OP_READ, 8'd252, 32'h0000_0000, 32'h0000_0001, tlc_pkg::SRC_L1},
    '{1'b1, tlc_pkg::OP_LOAD, 8'd16,  32'hDEAD_BEEF, 32'h0000_0000, tlc_pkg::SRC_LOAD},
    '{1'b1, tlc_pkg::OP_READ, 8'd16,  32'h0000_0000, 32'hDEAD_BEEF, tlc_pkg::SRC_MEM},
    '{1'b1, tlc_pkg::OP_READ, 8'd3,   32'h0000_0000, 32'h5A5A_5A5A, tlc_pkg::SRC_L2},
    '{1'b1, tlc_pkg::OP_LOAD, 8'd3,   32'h1111_1111, 32'h0000_0000, tlc_pkg::SRC_LOAD},
    '{1'b1, tlc_pkg::OP_READ, 8'd3,   32'h0000_0000, 32'h5A5A_5A5A, tlc_pkg::SRC_L1},
    '{1'b1, tlc_pkg::OP_LOAD, 8'd32,  32'h0F0F_0F0F, 32'h0000_0000, tlc_pkg::SRC_LOAD},
    '{1'b1, tlc_pkg::OP_READ, 8'd32,  32'h0000_0000, 32'h0F0F_0F0F, tlc_pkg::SRC_MEM},
    '{1'b1, tlc_pkg::OP_READ, 8'd0,   32'h0000_0000, 32'h0000_0000, tlc_pkg::SRC_MEM},
    '{1'b0, tlc_pkg::OP_READ, 8'd3,   32'h0000_0000, 32'h0000_0000, tlc_pkg::SRC_L1}
  };

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      in_valid_i   = 1'b0;
  logic                      operation_i  = 1'b0;
  logic [tlc_pkg::AddrW-1:0] address_i    = '0;
  logic [tlc_pkg::DataW-1:0] write_data_i = '0;
  logic                      out_stall_i  = 1'b0;
  logic                      in_stall_o;
  logic                      out_valid_o;
  logic [tlc_pkg::DataW-1:0] read_data_o;
  logic [tlc_pkg::SrcW-1:0]  source_o;

  two_level_direct_mapped_cache_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .source_o     (source_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of memory and both cache levels; *_loaded marks words that
  // hold a value that was actually loaded, so reads of junk are never issued.
  logic [tlc_pkg::DataW-1:0] mem_word   [tlc_pkg::MemWords];
  bit                        mem_loaded [tlc_pkg::MemWords];
  bit                        l1_valid   [tlc_pkg::L1Lines];
  logic [tlc_pkg::BlkW-1:0]  l1_tag     [tlc_pkg::L1Lines];
  logic [tlc_pkg::DataW-1:0] l1_word    [tlc_pkg::L1Lines*tlc_pkg::LineWords];
  bit                        l1_loaded  [tlc_pkg::L1Lines*tlc_pkg::LineWords];
  bit                        l2_valid   [tlc_pkg::L2Lines];
  logic [tlc_pkg::BlkW-1:0]  l2_tag     [tlc_pkg::L2Lines];
  logic [tlc_pkg::DataW-1:0] l2_word    [tlc_pkg::L2Lines*tlc_pkg::LineWords];
  bit                        l2_loaded  [tlc_pkg::L2Lines*tlc_pkg::LineWords];

  resp_t       pending_responses [$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  function automatic bit word_is_loaded(logic [tlc_pkg::AddrW-1:0] addr);
    logic [tlc_pkg::BlkW-1:0] blk;
    int unsigned              off, i1, i2;
    blk = addr[tlc_pkg::AddrW-1:tlc_pkg::OffW];
    off = 32'(addr[tlc_pkg::OffW-1:0]);
    i1  = blk % tlc_pkg::L1Lines;
    i2  = blk % tlc_pkg::L2Lines;
    if (l1_valid[i1] && l1_tag[i1] == blk) return l1_loaded[i1*tlc_pkg::LineWords + off];
    if (l2_valid[i2] && l2_tag[i2] == blk) return l2_loaded[i2*tlc_pkg::LineWords + off];
    return mem_loaded[addr];
  endfunction

  function automatic resp_t cache_lookup(tlc_pkg::tlc_op_e op,
                                         logic [tlc_pkg::AddrW-1:0] addr,
                                         logic [tlc_pkg::DataW-1:0] wdata);
    logic [tlc_pkg::BlkW-1:0] blk;
    int unsigned              off, i1, i2, base, w, m;
    resp_t                    r;
    blk  = addr[tlc_pkg::AddrW-1:tlc_pkg::OffW];
    off  = 32'(addr[tlc_pkg::OffW-1:0]);
    i1   = blk % tlc_pkg::L1Lines;
    i2   = blk % tlc_pkg::L2Lines;
    base = blk * tlc_pkg::LineWords;
    if (op == tlc_pkg::OP_LOAD) begin
      mem_word[addr]   = wdata;
      mem_loaded[addr] = 1'b1;
      r.data = '0;
      r.src  = tlc_pkg::SRC_LOAD;
      return r;
    end
    if (l1_valid[i1] && l1_tag[i1] == blk) begin
      r.data = l1_word[i1*tlc_pkg::LineWords + off];
      r.src  = tlc_pkg::SRC_L1;
      return r;
    end
    if (l2_valid[i2] && l2_tag[i2] == blk) begin
      r.data = l2_word[i2*tlc_pkg::LineWords + off];
      r.src  = tlc_pkg::SRC_L2;
    end else begin
      r.data = mem_word[addr];
      r.src  = tlc_pkg::SRC_MEM;
      l2_valid[i2] = 1'b1;
      l2_tag[i2]   = blk;
      for (w = 0; w < tlc_pkg::LineWords; w++) begin
        m = (base + w) % tlc_pkg::MemWords;
        l2_word[i2*tlc_pkg::LineWords + w]   = mem_word[m];
        l2_loaded[i2*tlc_pkg::LineWords + w] = mem_loaded[m];
      end
      l2_word[i2*tlc_pkg::LineWords + off]   = r.data;
      l2_loaded[i2*tlc_pkg::LineWords + off] = 1'b1;
    end
    // L1 refill always comes from memory, not from the L2 copy
    l1_valid[i1] = 1'b1;
    l1_tag[i1]   = blk;
    for (w = 0; w < tlc_pkg::LineWords; w++) begin
      m = (base + w) % tlc_pkg::MemWords;
      l1_word[i1*tlc_pkg::LineWords + w]   = mem_word[m];
      l1_loaded[i1*tlc_pkg::LineWords + w] = mem_loaded[m];
    end
    l1_word[i1*tlc_pkg::LineWords + off]   = r.data;
    l1_loaded[i1*tlc_pkg::LineWords + off] = 1'b1;
    return r;
  endfunction

  function automatic logic [tlc_pkg::DataW-1:0] rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Mostly a hot region of twelve blocks so hits and conflicts are common.
  function automatic logic [tlc_pkg::AddrW-1:0] pick_addr();
    if ($urandom_range(99) < 60) return tlc_pkg::AddrW'($urandom_range(47));
    return tlc_pkg::AddrW'($urandom_range(tlc_pkg::MemWords - 1));
  endfunction

  task automatic flag_error(string msg);
    if (error_count < MaxReports) $display("%s", msg);
    error_count++;
  endtask

  task automatic send_item(tlc_pkg::tlc_op_e op, logic [tlc_pkg::AddrW-1:0] addr,
                           logic [tlc_pkg::DataW-1:0] wdata,
                           bit known, resp_t known_resp);
    resp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    address_i    <= addr;
    write_data_i <= wdata;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = cache_lookup(op, addr, wdata);
    pending_responses.push_back(known ? known_resp : predicted);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    resp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_responses.size() == 0) begin
        flag_error($sformatf("unexpected item: data=%h source=%0d", read_data_o, source_o));
      end else begin
        want = pending_responses.pop_front();
        if (read_data_o !== want.data || source_o !== want.src) begin
          flag_error($sformatf("mismatch: data exp=%h got=%h, source exp=%0d got=%0d",
                               want.data, read_data_o, want.src, source_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL two_level_direct_mapped_cache_unit");
        $finish;
      end
    end
  end

  initial begin
    int unsigned               phase, sent, w;
    tlc_pkg::tlc_op_e          op;
    logic [tlc_pkg::AddrW-1:0] addr;
    logic [tlc_pkg::BlkW-1:0]  blk;

    send_idle_pct  = 16;
    recv_stall_pct = 87;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      send_item(DirectedRows[i].op, DirectedRows[i].addr, DirectedRows[i].wdata,
                DirectedRows[i].known, '{DirectedRows[i].data, DirectedRows[i].src});
    end

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 16;
          recv_stall_pct = 87;
        end
        1: begin
          send_idle_pct  = 87;
          recv_stall_pct = 16;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < RandomItems / 3) begin
        if ($urandom_range(7) == 0) begin
          // fill a whole block so later line fills carry only loaded words
          addr = pick_addr();
          blk  = addr[tlc_pkg::AddrW-1:tlc_pkg::OffW];
          for (w = 0; w < tlc_pkg::LineWords; w++) begin
            send_item(tlc_pkg::OP_LOAD, {blk, tlc_pkg::OffW'(w)}, rand_word(), 1'b0, '0);
          end
          sent += tlc_pkg::LineWords;
        end else begin
          op   = ($urandom_range(99) < 35) ? tlc_pkg::OP_LOAD : tlc_pkg::OP_READ;
          addr = pick_addr();
          if (op == tlc_pkg::OP_READ && !word_is_loaded(addr)) op = tlc_pkg::OP_LOAD;
          send_item(op, addr, rand_word(), 1'b0, '0);
          sent++;
        end
      end
      // hold off until every outstanding item has come back
      in_valid_i <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clk_i);
    end

    repeat (TailCycles) @(posedge clk_i);
    if (pending_responses.size() != 0) begin
      flag_error($sformatf("%0d items never came back", pending_responses.size()));
    end
    if (error_count == 0) begin
      $display("PASS two_level_direct_mapped_cache_unit");
    end else begin
      $display("FAIL two_level_direct_mapped_cache_unit");
    end
    $finish;
  end

endmodule
